// File: rtl/tidtt_pkg.sv
package tidtt_pkg;

    localparam int QUERY_ID_BITS = 10;
    localparam int RESULT_ID_BITS = 10;
    localparam int ENTRY_PAYLOAD_BITS = 64;
    localparam int REMOVED_COUNT_BITS = 11;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [2:0] CMD_ALLOCATE = 3'd0;
    localparam logic [2:0] CMD_POP = 3'd1;
    localparam logic [2:0] CMD_CLEANUP = 3'd2;
    localparam logic [2:0] CMD_TICK = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPIRY_TIMEOUT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAW_SEED = 1'd1;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] EXPIRY_RESET = 16'd5;
    localparam logic [15:0] LFSR_RESET = 16'd1;

    typedef struct packed {
        logic [2:0]                    command;
        logic [QUERY_ID_BITS-1:0]      query_id;
        logic [ENTRY_PAYLOAD_BITS-1:0] entry_payload;
    } req_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic [RESULT_ID_BITS-1:0]     result_id;
        logic [ENTRY_PAYLOAD_BITS-1:0] result_payload;
        logic [REMOVED_COUNT_BITS-1:0] removed_count;
    } rsp_t;

    typedef struct packed {
        logic       accept;
        logic       rd_draw;
        logic       rd_query;
        logic       rd_addr;
        logic       addr_init;
        logic       addr_init_one;
        logic       init_wr;
        logic       wr_alloc;
        logic       wr_kill;
        logic       cnt_inc;
        logic       tick;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_id;
        logic       res_pay;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic chk_free;
        logic chk_valid;
        logic chk_expired;
        logic qid_ok;
        logic addr_done;
        logic init_last;
        logic out_busy;
    } dp_stat_t;

endpackage

// File: rtl/tidtt_ctrl.sv
module tidtt_ctrl #(
    parameter int RANDOM_TRIES = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [2:0]          req_command,
    output logic                req_stall,
    input  tidtt_pkg::dp_stat_t stat,
    output tidtt_pkg::dp_cmd_t  cmd
);

    localparam int TRY_BITS = $clog2(RANDOM_TRIES + 2);

    localparam logic [3:0] S_INIT        = 4'd0;
    localparam logic [3:0] S_IDLE        = 4'd1;
    localparam logic [3:0] S_DRAW_CHK    = 4'd2;
    localparam logic [3:0] S_SCAN_FIRST  = 4'd3;
    localparam logic [3:0] S_SCAN        = 4'd4;
    localparam logic [3:0] S_POP_RD      = 4'd5;
    localparam logic [3:0] S_POP_CHK     = 4'd6;
    localparam logic [3:0] S_SWEEP_FIRST = 4'd7;
    localparam logic [3:0] S_SWEEP       = 4'd8;
    localparam logic [3:0] S_DONE        = 4'd9;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [TRY_BITS-1:0] try_reg;
    logic [TRY_BITS-1:0] try_next;
    logic [2:0]          op_reg;
    logic [2:0]          op_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        try_next = try_reg;
        op_next = op_reg;
        cmd = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    op_next = req_command;
                    case (req_command)
                        tidtt_pkg::CMD_ALLOCATE:
                        begin
                            if (RANDOM_TRIES != 0)
                            begin
                                cmd.rd_draw = 1'b1;
                                try_next = TRY_BITS'(1);
                                state_next = S_DRAW_CHK;
                            end
                            else
                            begin
                                cmd.addr_init = 1'b1;
                                cmd.addr_init_one = 1'b1;
                                state_next = S_SCAN_FIRST;
                            end
                        end
                        tidtt_pkg::CMD_POP:
                        begin
                            state_next = S_POP_RD;
                        end
                        tidtt_pkg::CMD_CLEANUP, tidtt_pkg::CMD_CLEAR:
                        begin
                            cmd.addr_init = 1'b1;
                            state_next = S_SWEEP_FIRST;
                        end
                        tidtt_pkg::CMD_TICK:
                        begin
                            cmd.tick = 1'b1;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DRAW_CHK:
            begin
                if (stat.chk_free)
                begin
                    cmd.wr_alloc = 1'b1;
                    cmd.res_set = 1'b1;
                    cmd.res_status = tidtt_pkg::ST_OK;
                    cmd.res_id = 1'b1;
                    state_next = S_DONE;
                end
                else if (try_reg == TRY_BITS'(RANDOM_TRIES))
                begin
                    cmd.addr_init = 1'b1;
                    cmd.addr_init_one = 1'b1;
                    state_next = S_SCAN_FIRST;
                end
                else
                begin
                    cmd.rd_draw = 1'b1;
                    try_next = try_reg + TRY_BITS'(1);
                end
            end
            S_SCAN_FIRST:
            begin
                cmd.rd_addr = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.chk_free)
                begin
                    cmd.wr_alloc = 1'b1;
                    cmd.res_set = 1'b1;
                    cmd.res_status = tidtt_pkg::ST_OK;
                    cmd.res_id = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.addr_done)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_status = tidtt_pkg::ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_addr = 1'b1;
                end
            end
            S_POP_RD:
            begin
                cmd.rd_query = 1'b1;
                state_next = S_POP_CHK;
            end
            S_POP_CHK:
            begin
                cmd.res_set = 1'b1;
                if (stat.chk_valid && stat.qid_ok)
                begin
                    cmd.wr_kill = 1'b1;
                    cmd.res_status = tidtt_pkg::ST_OK;
                    cmd.res_id = 1'b1;
                    cmd.res_pay = 1'b1;
                end
                else
                begin
                    cmd.res_status = tidtt_pkg::ST_NOT_FOUND;
                end
                state_next = S_DONE;
            end
            S_SWEEP_FIRST:
            begin
                cmd.rd_addr = 1'b1;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (stat.chk_valid && ((op_reg == tidtt_pkg::CMD_CLEAR) || stat.chk_expired))
                begin
                    cmd.wr_kill = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
                if (stat.addr_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_addr = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            try_reg <= '0;
            op_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            try_reg <= try_next;
            op_reg <= op_next;
        end
    end

endmodule

// File: rtl/tidtt_dp.sv
module tidtt_dp #(
    parameter int ID_BITS = 10,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [tidtt_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [tidtt_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  tidtt_pkg::req_t                          req,
    input  tidtt_pkg::dp_cmd_t                       cmd,
    output tidtt_pkg::dp_stat_t                      stat,
    input  logic                                     rsp_stall,
    output logic                                     rsp_valid,
    output tidtt_pkg::rsp_t                          rsp
);

    localparam int DEPTH = 1 << ID_BITS;
    localparam int ADDR_BITS = ID_BITS + 1;
    localparam int WORD_BITS = 1 + 32 + PAYLOAD_BITS;

    logic [WORD_BITS-1:0] mem [DEPTH];

    tidtt_pkg::req_t      item_reg;
    logic [15:0]          timeout_reg;
    logic [15:0]          lfsr_reg;
    logic [15:0]          lfsr_next;
    logic [31:0]          secs_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    logic [ID_BITS-1:0]   chk_id_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic [ADDR_BITS-1:0] cnt_reg;
    logic [1:0]           pend_status_reg;
    logic [ID_BITS-1:0]   pend_id_reg;
    logic [PAYLOAD_BITS-1:0] pend_pay_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tidtt_pkg::rsp_t      out_reg;

    logic [15:0]          lfsr_step;
    logic [ID_BITS-1:0]   draw_id;
    logic [ID_BITS-1:0]   query_idx;
    logic                 rd_en;
    logic [ID_BITS-1:0]   rd_addr;
    logic                 wr_en;
    logic [ID_BITS-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_word;
    logic                 chk_valid;
    logic [31:0]          chk_stamp;
    logic [PAYLOAD_BITS-1:0] chk_pay;

    assign lfsr_step = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? tidtt_pkg::LFSR_TAPS : 16'd0);
    assign draw_id = lfsr_step[ID_BITS-1:0];
    assign query_idx = ID_BITS'(item_reg.query_id);

    assign chk_valid = rd_word_reg[WORD_BITS-1];
    assign chk_stamp = rd_word_reg[PAYLOAD_BITS+31:PAYLOAD_BITS];
    assign chk_pay = rd_word_reg[PAYLOAD_BITS-1:0];

    assign stat.chk_valid = chk_valid;
    assign stat.chk_free = !chk_valid && (chk_id_reg != '0);
    assign stat.chk_expired = (secs_reg - chk_stamp) > {16'd0, timeout_reg};
    assign stat.qid_ok = (32'(item_reg.query_id) < 32'(DEPTH));
    assign stat.addr_done = (addr_reg == ADDR_BITS'(DEPTH));
    assign stat.init_last = (addr_reg[ID_BITS-1:0] == {ID_BITS{1'b1}});
    assign stat.out_busy = out_valid_reg && rsp_stall;

    always_comb
    begin
        rd_en = cmd.rd_draw || cmd.rd_query || cmd.rd_addr;
        rd_addr = addr_reg[ID_BITS-1:0];
        if (cmd.rd_draw)
        begin
            rd_addr = draw_id;
        end
        else if (cmd.rd_query)
        begin
            rd_addr = query_idx;
        end
        wr_en = cmd.init_wr || cmd.wr_alloc || cmd.wr_kill;
        wr_addr = chk_id_reg;
        wr_word = '0;
        if (cmd.init_wr)
        begin
            wr_addr = addr_reg[ID_BITS-1:0];
        end
        else if (cmd.wr_alloc)
        begin
            wr_word = {1'b1, secs_reg, item_reg.entry_payload[PAYLOAD_BITS-1:0]};
        end
    end

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (cfg_write && (cfg_index == tidtt_pkg::CFG_DRAW_SEED))
        begin
            lfsr_next = (cfg_data != 16'd0) ? cfg_data : tidtt_pkg::LFSR_RESET;
        end
        else if (cmd.rd_draw)
        begin
            lfsr_next = lfsr_step;
        end
        addr_next = addr_reg;
        if (cmd.addr_init)
        begin
            addr_next = cmd.addr_init_one ? ADDR_BITS'(1) : '0;
        end
        else if (cmd.rd_addr || cmd.init_wr)
        begin
            addr_next = addr_reg + ADDR_BITS'(1);
        end
        out_valid_next = cmd.out_load || (out_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
            chk_id_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req;
            pend_status_reg <= tidtt_pkg::ST_OK;
            pend_id_reg <= '0;
            pend_pay_reg <= '0;
        end
        else if (cmd.res_set)
        begin
            pend_status_reg <= cmd.res_status;
            if (cmd.res_id)
            begin
                pend_id_reg <= chk_id_reg;
            end
            if (cmd.res_pay)
            begin
                pend_pay_reg <= chk_pay;
            end
        end
        if (cmd.out_load)
        begin
            out_reg.status <= pend_status_reg;
            out_reg.result_id <= tidtt_pkg::RESULT_ID_BITS'(pend_id_reg);
            out_reg.result_payload <= tidtt_pkg::ENTRY_PAYLOAD_BITS'(pend_pay_reg);
            out_reg.removed_count <= tidtt_pkg::REMOVED_COUNT_BITS'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= tidtt_pkg::EXPIRY_RESET;
            lfsr_reg <= tidtt_pkg::LFSR_RESET;
            secs_reg <= '0;
            addr_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == tidtt_pkg::CFG_EXPIRY_TIMEOUT))
            begin
                timeout_reg <= cfg_data;
            end
            lfsr_reg <= lfsr_next;
            if (cmd.tick)
            begin
                secs_reg <= secs_reg + 32'd1;
            end
            addr_reg <= addr_next;
            if (cmd.accept)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + ADDR_BITS'(1);
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

endmodule

// File: rtl/transaction_id_translation_table.sv
// Hands out forwarded transaction IDs (1 to 2^ID_BITS-1) bound to a payload and the
// tick count at allocation. All entries live in one table memory with one read and one
// write port, read one ID per cycle. After reset a clearing pass writes every entry,
// during which no transaction is accepted (configuration writes are taken). Per
// transaction: tick bumps the tick count, unknown commands do nothing but answer, pop
// reads the queried ID, allocate tries random draws and, if all draws fail, scans the
// IDs one by one from 1, and cleanup or clear sweeps every ID.
// A new transaction is taken while the previous result still waits in the output register.
module transaction_id_translation_table #(
    parameter int ID_BITS = 10,
    parameter int PAYLOAD_BITS = 64,
    parameter int RANDOM_TRIES = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tidtt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tidtt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  tidtt_pkg::req_t                      req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output tidtt_pkg::rsp_t                      rsp
);

    tidtt_pkg::dp_cmd_t  cmd;
    tidtt_pkg::dp_stat_t stat;

    tidtt_ctrl #(
        .RANDOM_TRIES(RANDOM_TRIES)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_command(req.command),
        .req_stall(req_stall),
        .stat(stat),
        .cmd(cmd)
    );

    tidtt_dp #(
        .ID_BITS(ID_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req),
        .cmd(cmd),
        .stat(stat),
        .rsp_stall(rsp_stall),
        .rsp_valid(rsp_valid),
        .rsp(rsp)
    );

    a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == tidtt_pkg::ST_FULL) |-> (rsp.result_id == '0))
        else $error("full result carries an ID");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != tidtt_pkg::ST_OK)
        |-> (rsp.result_payload == '0) && (rsp.removed_count == '0))
        else $error("failed result carries data");

    a_count_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.removed_count != '0) |-> (rsp.result_id == '0))
        else $error("removal result carries an ID");

endmodule

// File: tb/transaction_id_translation_table_tb.sv
module transaction_id_translation_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1024;
    localparam int DRAW_TRIES = 20;
    localparam int STALL_LIMIT = 20000;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_write = 1'b0;
    logic [tidtt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [tidtt_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                                 req_valid = 1'b0;
    logic                                 req_stall;
    tidtt_pkg::req_t                      req = '0;
    logic                                 rsp_valid;
    logic                                 rsp_stall = 1'b0;
    tidtt_pkg::rsp_t                      rsp;

    transaction_id_translation_table dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow of the table
    bit          id_live [TABLE_DEPTH];
    logic [63:0] id_payload [TABLE_DEPTH];
    logic [31:0] id_stamp [TABLE_DEPTH];
    logic [31:0] tick_count = '0;
    logic [15:0] draw_state = tidtt_pkg::LFSR_RESET;
    logic [15:0] age_limit = tidtt_pkg::EXPIRY_RESET;

    tidtt_pkg::rsp_t pending_rsp[$];
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   mismatches = 0;
    int   sent = 0;
    int   received = 0;
    int   full_seen = 0;
    int   expired_seen = 0;
    int   idle_cycles = 0;

    function automatic logic [9:0] next_draw();
        logic low_bit;
        low_bit = draw_state[0];
        draw_state = draw_state >> 1;
        if (low_bit)
            draw_state = draw_state ^ tidtt_pkg::LFSR_TAPS;
        return draw_state[9:0];
    endfunction

    function automatic tidtt_pkg::rsp_t predict_response(tidtt_pkg::req_t r);
        tidtt_pkg::rsp_t o;
        logic [9:0]      cand;
        int              granted;
        o = '0;
        granted = 0;
        case (r.command)
            tidtt_pkg::CMD_ALLOCATE:
            begin
                for (int t = 0; t < DRAW_TRIES; t++)
                begin
                    if (granted == 0)
                    begin
                        cand = next_draw();
                        if (cand != 0 && !id_live[cand])
                            granted = cand;
                    end
                end
                for (int k = 1; k < TABLE_DEPTH; k++)
                    if (granted == 0 && !id_live[k])
                        granted = k;
                if (granted != 0)
                begin
                    id_live[granted] = 1'b1;
                    id_payload[granted] = r.entry_payload;
                    id_stamp[granted] = tick_count;
                    o.result_id = granted[9:0];
                end
                else
                begin
                    o.status = tidtt_pkg::ST_FULL;
                    full_seen++;
                end
            end
            tidtt_pkg::CMD_POP:
            begin
                if (id_live[r.query_id])
                begin
                    o.result_id = r.query_id;
                    o.result_payload = id_payload[r.query_id];
                    id_live[r.query_id] = 1'b0;
                end
                else
                    o.status = tidtt_pkg::ST_NOT_FOUND;
            end
            tidtt_pkg::CMD_CLEANUP:
            begin
                for (int k = 0; k < TABLE_DEPTH; k++)
                    if (id_live[k] && (tick_count - id_stamp[k]) > {16'd0, age_limit})
                    begin
                        id_live[k] = 1'b0;
                        o.removed_count++;
                    end
                expired_seen += o.removed_count;
            end
            tidtt_pkg::CMD_TICK:
                tick_count = tick_count + 1;
            tidtt_pkg::CMD_CLEAR:
            begin
                for (int k = 0; k < TABLE_DEPTH; k++)
                    if (id_live[k])
                    begin
                        id_live[k] = 1'b0;
                        o.removed_count++;
                    end
            end
            default:
                ;
        endcase
        return o;
    endfunction

    function automatic logic [9:0] some_live_id();
        int start;
        start = $urandom_range(TABLE_DEPTH - 1);
        for (int k = 0; k < TABLE_DEPTH; k++)
            if (id_live[(start + k) % TABLE_DEPTH])
                return 10'((start + k) % TABLE_DEPTH);
        return 10'($urandom_range(TABLE_DEPTH - 1));
    endfunction

    task automatic send(logic [2:0] cmd, logic [9:0] qid, logic [63:0] pay);
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req = '{command: cmd, query_id: qid, entry_payload: pay};
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        pending_rsp.push_back(predict_response(req));
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [tidtt_pkg::CFG_INDEX_BITS-1:0] idx, logic [15:0] value);
        drain();
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        if (idx == tidtt_pkg::CFG_EXPIRY_TIMEOUT)
            age_limit = value;
        else
            draw_state = (value == 0) ? tidtt_pkg::LFSR_RESET : value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic test_basic_commands();
        logic [9:0] id_a;
        send(tidtt_pkg::CMD_ALLOCATE, 10'd0, 64'd0);
        send(tidtt_pkg::CMD_ALLOCATE, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(tidtt_pkg::CMD_ALLOCATE, 10'h155, 64'hA5A5_5A5A_0F0F_F0F0);
        id_a = some_live_id();
        send(tidtt_pkg::CMD_POP, id_a, 64'd0);
        send(tidtt_pkg::CMD_POP, id_a, 64'd0);
        send(tidtt_pkg::CMD_POP, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send(tidtt_pkg::CMD_POP, 10'h3FF, 64'd0);
        send(3'd5, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(3'd6, 10'd0, 64'd0);
        send(3'd7, 10'h2AA, 64'h1234);
        send(tidtt_pkg::CMD_CLEANUP, 10'd0, 64'd0);
        repeat (6) send(tidtt_pkg::CMD_TICK, 10'd0, 64'd0);
        send(tidtt_pkg::CMD_ALLOCATE, 10'd0, 64'h7);
        send(tidtt_pkg::CMD_CLEANUP, 10'd0, 64'd0);
        send(tidtt_pkg::CMD_CLEAR, 10'd0, 64'd0);
        send(tidtt_pkg::CMD_POP, some_live_id(), 64'd0);
    endtask

    task automatic test_register_extremes();
        write_reg(tidtt_pkg::CFG_DRAW_SEED, 16'd0);
        write_reg(tidtt_pkg::CFG_EXPIRY_TIMEOUT, 16'd0);
        send(tidtt_pkg::CMD_ALLOCATE, 10'd0, 64'h11);
        send(tidtt_pkg::CMD_ALLOCATE, 10'd0, 64'h22);
        send(tidtt_pkg::CMD_CLEANUP, 10'd0, 64'd0);
        send(tidtt_pkg::CMD_TICK, 10'd0, 64'd0);
        send(tidtt_pkg::CMD_CLEANUP, 10'd0, 64'd0);
        write_reg(tidtt_pkg::CFG_EXPIRY_TIMEOUT, 16'hFFFF);
        write_reg(tidtt_pkg::CFG_DRAW_SEED, 16'hFFFF);
        send(tidtt_pkg::CMD_ALLOCATE, 10'd0, 64'h33);
        send(tidtt_pkg::CMD_ALLOCATE, 10'd0, 64'h44);
        repeat (3) send(tidtt_pkg::CMD_TICK, 10'd0, 64'd0);
        send(tidtt_pkg::CMD_CLEANUP, 10'd0, 64'd0);
        send(tidtt_pkg::CMD_CLEAR, 10'd0, 64'd0);
    endtask

    task automatic test_full_table();
        gap_pct = 0;
        stall_pct = 0;
        write_reg(tidtt_pkg::CFG_DRAW_SEED, 16'h1D2B);
        repeat (TABLE_DEPTH - 1)
            send(tidtt_pkg::CMD_ALLOCATE, 10'd0, {$urandom, $urandom});
        send(tidtt_pkg::CMD_ALLOCATE, 10'd0, 64'hDEAD);
        send(tidtt_pkg::CMD_POP, 10'd512, 64'd0);
        send(tidtt_pkg::CMD_ALLOCATE, 10'd0, 64'hBEEF);
        send(tidtt_pkg::CMD_ALLOCATE, 10'd0, 64'hF00D);
        send(tidtt_pkg::CMD_CLEAR, 10'd0, 64'd0);
    endtask

    task automatic test_random_mix(int count, int gap, int stall, logic [15:0] limit,
                                   logic [15:0] seed);
        int pick;
        write_reg(tidtt_pkg::CFG_EXPIRY_TIMEOUT, limit);
        write_reg(tidtt_pkg::CFG_DRAW_SEED, seed);
        gap_pct = gap;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain();
            pick = $urandom_range(99);
            if (pick < 42)
                send(tidtt_pkg::CMD_ALLOCATE, 10'($urandom), {$urandom, $urandom});
            else if (pick < 62)
                send(tidtt_pkg::CMD_POP, some_live_id(), {$urandom, $urandom});
            else if (pick < 72)
                send(tidtt_pkg::CMD_POP, 10'($urandom), {$urandom, $urandom});
            else if (pick < 90)
                send(tidtt_pkg::CMD_TICK, 10'($urandom), {$urandom, $urandom});
            else if (pick < 94)
                send(3'($urandom_range(5, 7)), 10'($urandom), {$urandom, $urandom});
            else if (pick < 99)
                send(tidtt_pkg::CMD_CLEANUP, 10'($urandom), {$urandom, $urandom});
            else
                send(tidtt_pkg::CMD_CLEAR, 10'($urandom), {$urandom, $urandom});
        end
        drain();
    endtask

    always @(negedge clk)
        rsp_stall = ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            received++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %p", rsp);
            end
            else if (rsp !== pending_rsp[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", pending_rsp[0], rsp);
                void'(pending_rsp.pop_front());
            end
            else
                void'(pending_rsp.pop_front());
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_basic_commands();
        test_register_extremes();
        test_full_table();
        test_random_mix(24, 0, 0, 16'd3, 16'hACE1);
        test_random_mix(24, 70, 0, 16'd8, 16'h0001);
        test_random_mix(24, 0, 70, 16'd1, 16'h8000);
        test_random_mix(24, 25, 25, 16'd12, 16'h5A5A);
        drain();
        $display("covered %0d transactions (%0d results), %0d full answers, %0d expired",
                 sent, received, full_seen, expired_seen);
        $display("mismatches: %0d, results still pending: %0d",
                 mismatches, pending_rsp.size());
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
